// File: rtl/core/blce_pkg.sv
package blce_pkg;

   localparam int NUM_COMPONENTS = 3;
   localparam int COMP_IDX_W     = $clog2(NUM_COMPONENTS);

   localparam logic [2:0]  HOLDOFF_ITEMS = 3'd5;
   localparam logic [15:0] RISE_LIMIT    = 16'd204;
   localparam logic [23:0] VALUE_MAX     = 24'hFFFFFF;
   localparam logic signed [15:0] LIFE_MIN = 16'sh8000;

   // Reciprocal of five for 21-bit dividends: floor(x * M / 2^24) == floor(x / 5).
   localparam logic [21:0] DIV5_RECIP = 22'd3355444;

   localparam logic [13:0] TRI_PEAK     = 14'd1536;
   localparam logic [12:0] CENTRE_RED_A = 13'd0;
   localparam logic [12:0] CENTRE_RED_B = 13'd3072;
   localparam logic [12:0] CENTRE_GREEN = 13'd1024;
   localparam logic [12:0] CENTRE_BLUE  = 13'd2048;

   localparam logic [7:0] RED_MAX   = 8'd255;
   localparam logic [7:0] GREEN_MAX = 8'd63;
   localparam logic [7:0] BLUE_MAX  = 8'd23;

   localparam logic ACTION_LEVEL = 1'b0;
   localparam logic ACTION_TICK  = 1'b1;

   typedef struct packed {
      logic        action;
      logic [15:0] level;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_payload_type;

   typedef logic [23:0] comp_value_type;

   // Division of a 24-bit value by forty: a shift by three, then a division by five.
   function automatic logic [18:0] div40(input logic [23:0] x);
      logic [43:0] prod;
      prod = 44'(x[23:3]) * 44'(DIV5_RECIP);
      return prod[42:24];
   endfunction

   function automatic logic [10:0] tri_level(input logic [10:0] p, input logic [12:0] c);
      logic [13:0] three_p;
      logic [13:0] two_c;
      logic [13:0] span;
      three_p = (14'(p) << 1) + 14'(p);
      two_c   = 14'(c) << 1;
      span    = (three_p >= two_c) ? (three_p - two_c) : (two_c - three_p);
      return (span >= TRI_PEAK) ? 11'd0 : 11'(TRI_PEAK - span);
   endfunction

   function automatic logic [7:0] scale_idle(input logic [10:0] t, input logic [7:0] maxv);
      logic [18:0] prod;
      logic [7:0]  q;
      prod = 19'(t) * 19'(maxv);
      q    = prod[18:11];
      if (q == 8'd0) begin
         q = 8'd1;
      end
      if (q > maxv) begin
         q = maxv;
      end
      return q;
   endfunction

   function automatic logic [7:0] scale_active(input logic [23:0] v);
      logic [31:0] prod;
      logic [11:0] q;
      prod = 32'(v) * 32'd255;
      q    = prod[31:20];
      if (q == 12'd0) begin
         return 8'd1;
      end else if (q > 12'd255) begin
         return 8'd255;
      end else begin
         return q[7:0];
      end
   endfunction

endpackage

// File: rtl/core/blce_color.sv
module blce_color
   import blce_pkg::*;
(
   input  logic            idle_mode,
   input  logic [10:0]     phase,
   input  comp_value_type  comp_value [NUM_COMPONENTS],
   output rsp_payload_type color
);

   logic [10:0] tri_red_a;
   logic [10:0] tri_red_b;
   logic [10:0] tri_red;
   logic [10:0] tri_green;
   logic [10:0] tri_blue;

   always_comb begin
      tri_red_a = tri_level(phase, CENTRE_RED_A);
      tri_red_b = tri_level(phase, CENTRE_RED_B);
      tri_red   = (tri_red_b > tri_red_a) ? tri_red_b : tri_red_a;
      tri_green = tri_level(phase, CENTRE_GREEN);
      tri_blue  = tri_level(phase, CENTRE_BLUE);
      if (idle_mode) begin
         color.red   = scale_idle(tri_red, RED_MAX);
         color.green = scale_idle(tri_green, GREEN_MAX);
         color.blue  = scale_idle(tri_blue, BLUE_MAX);
      end else begin
         color.red   = scale_active(comp_value[0]);
         color.green = scale_active(comp_value[1]);
         color.blue  = scale_active(comp_value[2]);
      end
   end

endmodule

// File: rtl/core/beat_light_color_engine_core.sv
// Beat light colour engine.
// The req channel carries one transaction per level sample (action level) or per
// render tick (action tick). Level transactions update the beat envelope and may
// load a colour component; they never produce a response. Tick transactions render
// one colour, either a rainbow (idle_mode set) or the decaying beat colours, and
// produce a response on the rsp channel only when the colour differs from the
// last one sent.
// csr_wr_en with csr_wr_data writes idle_mode; write it only while the block is idle.
// A transaction accepted into the input register is processed once it can advance; a tick
// that produces a response loads it into the result register, which drives rsp_valid.
// Throughput: one transaction per cycle while no stalled response waits, set by the
// single input register and the single result register.
// While rsp_stall holds a waiting response, nothing in the input register is
// processed, level or tick, so req_stall rises as soon as that register is full;
// both move on at the edge where the response is taken.
// Reset (synchronous, active high) clears all state, selects idle mode and empties
// both registers; the first tick after reset always produces a response.
module beat_light_color_engine_core
   import blce_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   logic            idle_mode_ff;
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_payload_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_payload_ff;

   logic [15:0]       prev_level_ff, prev_level_in;
   logic [23:0]       env_ff, env_in;
   logic [23:0]       env_step_ff, env_step_in;
   logic [2:0]        holdoff_ff, holdoff_in;
   comp_value_type    comp_value_ff [NUM_COMPONENTS];
   comp_value_type    comp_value_in [NUM_COMPONENTS];
   logic [23:0]       comp_step_ff [NUM_COMPONENTS];
   logic [23:0]       comp_step_in [NUM_COMPONENTS];
   logic signed [15:0] comp_life_ff [NUM_COMPONENTS];
   logic signed [15:0] comp_life_in [NUM_COMPONENTS];
   logic [10:0]       phase_ff, phase_in;
   rsp_payload_type   last_color_ff, last_color_in;
   logic              color_sent_ff, color_sent_in;

   logic            req_accept;
   logic            advance;
   logic            is_tick;
   logic            trigger;
   logic [15:0]     diff;
   logic [23:0]     level20;
   logic [22:0]     life_prod;
   logic [23:0]     new_value;
   logic [COMP_IDX_W-1:0] pick;
   logic [23:0]     env_t;
   logic [23:0]     step_t;
   logic            emit;
   rsp_payload_type color;

   blce_color u_color (
      .idle_mode  (idle_mode_ff),
      .phase      (phase_ff),
      .comp_value (comp_value_ff),
      .color      (color)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_payload = out_payload_ff;

   assign is_tick = (in_payload_ff.action == ACTION_TICK);
   assign diff    = in_payload_ff.level - prev_level_ff;
   assign level20 = {in_payload_ff.level, 8'd0};
   assign trigger = !is_tick && (in_payload_ff.level > prev_level_ff) && (diff > RISE_LIMIT)
                    && (level20 > env_ff) && (holdoff_ff == 3'd0);
   assign emit    = advance && is_tick && (!color_sent_ff || (color != last_color_ff));

   always_comb begin
      life_prod = 23'(diff) * 23'd100;
      new_value = (diff[15:14] != 2'd0) ? VALUE_MAX : {diff[13:0], 10'd0};

      // Least-alive component wins; the lowest index wins a tie.
      pick = '0;
      for (int k = 1; k < NUM_COMPONENTS; k++) begin
         if (comp_life_ff[k] < comp_life_ff[pick]) begin
            pick = COMP_IDX_W'(k);
         end
      end

      prev_level_in = prev_level_ff;
      env_in        = env_ff;
      env_step_in   = env_step_ff;
      holdoff_in    = holdoff_ff;
      phase_in      = phase_ff;
      last_color_in = last_color_ff;
      color_sent_in = color_sent_ff;
      comp_value_in = comp_value_ff;
      comp_step_in  = comp_step_ff;
      comp_life_in  = comp_life_ff;
      env_t         = trigger ? level20 : env_ff;
      step_t        = trigger ? 24'(div40(level20)) : env_step_ff;

      if (advance && !is_tick) begin
         if (trigger) begin
            holdoff_in          = HOLDOFF_ITEMS - 3'd1;
            comp_life_in[pick]  = 16'(life_prod[22:12]);
            comp_value_in[pick] = new_value;
            comp_step_in[pick]  = 24'(div40(new_value));
         end else if (holdoff_ff != 3'd0) begin
            holdoff_in = holdoff_ff - 3'd1;
         end
         if (step_t > env_t) begin
            env_in      = '0;
            env_step_in = '0;
         end else begin
            env_in      = env_t - step_t;
            env_step_in = step_t;
         end
         prev_level_in = in_payload_ff.level;
      end else if (advance && is_tick) begin
         if (idle_mode_ff) begin
            phase_in = phase_ff + 11'd1;
         end else begin
            for (int k = 0; k < NUM_COMPONENTS; k++) begin
               if (comp_life_ff[k] != LIFE_MIN) begin
                  comp_life_in[k] = comp_life_ff[k] - 16'sd1;
               end
               if (comp_step_ff[k] > comp_value_ff[k]) begin
                  comp_value_in[k] = '0;
                  comp_step_in[k]  = '0;
               end else begin
                  comp_value_in[k] = comp_value_ff[k] - comp_step_ff[k];
               end
            end
         end
         if (emit) begin
            last_color_in = color;
            color_sent_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_mode_ff  <= 1'b1;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         prev_level_ff <= '0;
         env_ff        <= '0;
         env_step_ff   <= '0;
         holdoff_ff    <= '0;
         phase_ff      <= '0;
         last_color_ff <= '0;
         color_sent_ff <= 1'b0;
         for (int k = 0; k < NUM_COMPONENTS; k++) begin
            comp_value_ff[k] <= '0;
            comp_step_ff[k]  <= '0;
            comp_life_ff[k]  <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            idle_mode_ff <= csr_wr_data;
         end
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         prev_level_ff <= prev_level_in;
         env_ff        <= env_in;
         env_step_ff   <= env_step_in;
         holdoff_ff    <= holdoff_in;
         phase_ff      <= phase_in;
         last_color_ff <= last_color_in;
         color_sent_ff <= color_sent_in;
         comp_value_ff <= comp_value_in;
         comp_step_ff  <= comp_step_in;
         comp_life_ff  <= comp_life_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_payload_ff <= req_payload;
      end
      if (emit) begin
         out_payload_ff <= color;
      end
   end

   // A response that is waiting on a stalled receiver must block further processing.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !advance)
      else $error("transaction processed while a stalled response waits");

   // The colour just sent becomes the reference for suppressing repeats.
   assert property (@(posedge clock) disable iff (reset)
      emit |=> (rsp_valid && color_sent_ff && (last_color_ff == rsp_payload)))
      else $error("sent colour and last colour disagree");

   // Level transactions never produce a response.
   assert property (@(posedge clock) disable iff (reset)
      (advance && !is_tick) |-> !emit)
      else $error("level transaction produced a response");

   // A beat trigger starts the hold-off, already counted down by one.
   assert property (@(posedge clock) disable iff (reset)
      (advance && trigger) |=> (holdoff_ff == HOLDOFF_ITEMS - 3'd1))
      else $error("hold-off not started by trigger");

endmodule

// File: dv/tb_beat_light_color_engine_core.sv
module tb_beat_light_color_engine_core
   import blce_pkg::*;
();

   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 85;
   localparam int WEAR_TICKS    = 40;
   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 150;
   localparam int MAX_GAP       = 80;
   localparam int RISE_MIN      = 204;
   localparam int HOLD_ITEMS    = 5;
   localparam logic signed [15:0] LIFE_FLOOR = 16'sh8000;

   typedef enum int {PACE_FREE, PACE_SEND_SLOW, PACE_RECV_SLOW, PACE_BOTH_LIGHT} pace_type;
   typedef enum bit {STEP_ITEM, STEP_MODE} step_kind_type;

   typedef struct {
      step_kind_type   kind;
      req_payload_type txn;
      bit              pinned;
      bit              pin_emit;
      rsp_payload_type pin_rgb;
      bit              mode;
   } plan_step_type;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en   = 1'b0;
   logic            csr_wr_data = 1'b0;

   // Shadow of the colour engine state.
   bit                  mode_idle     = 1'b1;
   logic [15:0]         prev_level    = '0;
   logic [23:0]         envelope      = '0;
   logic [23:0]         envelope_step = '0;
   logic [2:0]          holdoff_left  = '0;
   logic [23:0]         comp_value [3] = '{24'd0, 24'd0, 24'd0};
   logic [23:0]         comp_step [3]  = '{24'd0, 24'd0, 24'd0};
   logic signed [15:0]  comp_life [3]  = '{16'sd0, 16'sd0, 16'sd0};
   logic [10:0]         rainbow_phase = '0;
   rsp_payload_type     last_rgb      = '0;
   bit                  rgb_sent      = 1'b0;

   rsp_payload_type pending_colours [$];
   plan_step_type   script [$];
   pace_type        pace       = PACE_FREE;
   bit              hold_armed = 1'b0;
   int              mismatches = 0;
   int              walk       = 0;

   beat_light_color_engine_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic wear(inout logic [23:0] amount, inout logic [23:0] step);
      if (step > amount) begin
         amount = '0;
         step   = '0;
      end else begin
         amount = amount - step;
      end
   endtask

   function automatic int ramp(int p, int centre);
      int d;
      d = 3 * p - 2 * centre;
      if (d < 0) begin
         d = -d;
      end
      return (d >= 1536) ? 0 : 1536 - d;
   endfunction

   function automatic logic [7:0] shade(int t, int top);
      int v;
      v = t * top / 2048;
      if (v < 1) begin
         v = 1;
      end
      if (v > top) begin
         v = top;
      end
      return 8'(v);
   endfunction

   function automatic logic [7:0] glow(logic [23:0] v);
      longint s;
      s = (longint'(v) * 255) >> 20;
      if (s < 1) begin
         s = 1;
      end
      if (s > 255) begin
         s = 255;
      end
      return 8'(s);
   endfunction

   task automatic absorb_level(input logic [15:0] lvl);
      int          rise;
      int          pick;
      longint      boosted;
      logic [23:0] lvl_wide;
      rise     = int'(lvl) - int'(prev_level);
      lvl_wide = {lvl, 8'h00};
      if (rise > RISE_MIN && lvl_wide > envelope && holdoff_left == 3'd0) begin
         holdoff_left  = 3'(HOLD_ITEMS);
         envelope      = lvl_wide;
         envelope_step = envelope / 24'd40;
         // The least alive component is reloaded; ties go to the lowest index.
         pick = 0;
         for (int k = 1; k < 3; k++) begin
            if (comp_life[k] < comp_life[pick]) begin
               pick = k;
            end
         end
         comp_life[pick]  = 16'(rise * 100 / 4096);
         boosted          = longint'(rise) << 10;
         comp_value[pick] = (boosted > 64'hFFFFFF) ? 24'hFFFFFF : 24'(boosted);
         comp_step[pick]  = comp_value[pick] / 24'd40;
      end
      if (holdoff_left != 3'd0) begin
         holdoff_left--;
      end
      wear(envelope, envelope_step);
      prev_level = lvl;
   endtask

   task automatic render_colour(output bit emit, output rsp_payload_type rgb);
      int p;
      int red_t;
      if (mode_idle) begin
         p     = int'(rainbow_phase);
         red_t = ramp(p, 0);
         if (ramp(p, 3072) > red_t) begin
            red_t = ramp(p, 3072);
         end
         rgb.red   = shade(red_t, 255);
         rgb.green = shade(ramp(p, 1024), 63);
         rgb.blue  = shade(ramp(p, 2048), 23);
         rainbow_phase++;
      end else begin
         rgb.red   = glow(comp_value[0]);
         rgb.green = glow(comp_value[1]);
         rgb.blue  = glow(comp_value[2]);
         for (int k = 0; k < 3; k++) begin
            if (comp_life[k] != LIFE_FLOOR) begin
               comp_life[k]--;
            end
            wear(comp_value[k], comp_step[k]);
         end
      end
      emit = !(rgb_sent && rgb == last_rgb);
      if (emit) begin
         last_rgb = rgb;
         rgb_sent = 1'b1;
      end
   endtask

   function automatic void plan_item(bit action, int level);
      plan_step_type s;
      s.kind       = STEP_ITEM;
      s.txn.action = action;
      s.txn.level  = 16'(level);
      s.pinned     = 1'b0;
      s.pin_emit   = 1'b0;
      s.pin_rgb    = '0;
      s.mode       = 1'b0;
      script.push_back(s);
   endfunction

   function automatic void plan_pinned(bit action, int level, bit emit,
                                       int red, int green, int blue);
      plan_item(action, level);
      script[$].pinned   = 1'b1;
      script[$].pin_emit = emit;
      script[$].pin_rgb  = {8'(red), 8'(green), 8'(blue)};
   endfunction

   function automatic void plan_mode(bit value);
      plan_item(ACTION_TICK, 0);
      script[$].kind = STEP_MODE;
      script[$].mode = value;
   endfunction

   function automatic req_payload_type draw_sample();
      req_payload_type txn;
      int              r;
      r = int'($urandom_range(99));
      if (r < 40) begin
         txn.action = ACTION_TICK;
         txn.level  = 16'($urandom);
         return txn;
      end
      txn.action = ACTION_LEVEL;
      r = int'($urandom_range(99));
      // Beats most often: sharp rises over a falling background, with noise and jumps mixed in.
      if (r < 40) begin
         walk = walk + int'($urandom_range(205, 9000));
         if (walk > 65535) begin
            walk = int'($urandom_range(0, 2000));
         end
      end else if (r < 70) begin
         walk = walk - int'($urandom_range(0, walk));
      end else if (r < 82) begin
         walk = walk + int'($urandom_range(0, 408)) - 204;
         if (walk < 0) begin
            walk = 0;
         end
         if (walk > 65535) begin
            walk = 65535;
         end
      end else if (r < 95) begin
         walk = int'($urandom_range(0, 65535));
      end else begin
         walk = ($urandom_range(1) == 1) ? 65535 : 0;
      end
      txn.level = 16'(walk);
      return txn;
   endfunction

   task automatic offer(input req_payload_type txn, input bit pinned, input bit pin_emit,
                        input rsp_payload_type pin_rgb);
      int              gap;
      int              pct;
      bit              emit;
      rsp_payload_type rgb;
      gap = 0;
      pct = (pace == PACE_SEND_SLOW) ? 84 : (pace == PACE_BOTH_LIGHT) ? 10 : 0;
      while (int'($urandom_range(99)) < pct && gap < MAX_GAP) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= txn;
      // Stall is stable from the falling edge on, so this edge decides acceptance.
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      if (txn.action == ACTION_LEVEL) begin
         absorb_level(txn.level);
         emit = 1'b0;
         rgb  = '0;
      end else begin
         render_colour(emit, rgb);
      end
      if (pinned) begin
         emit = pin_emit;
         rgb  = pin_rgb;
      end
      if (emit) begin
         pending_colours.push_back(rgb);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_colours.size() != 0) @(posedge clock);
      // Level transactions may still be in the pipeline with nothing to wait for.
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input bit value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mode_idle = value;
   endtask

   task automatic set_pace(input pace_type p, input bit long_hold);
      @(negedge clock);
      pace = p;
      if (long_hold) begin
         hold_armed = 1'b1;
      end
      @(posedge clock);
   endtask

   task automatic flag(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: expected %0d, got %0d", what, want, got);
      end
   endtask

   initial begin : receiver
      int hold_left;
      int pct;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_armed) begin
            hold_left  = HOLD_CYCLES;
            hold_armed = 1'b0;
         end
         pct = (pace == PACE_RECV_SLOW) ? 84 : (pace == PACE_BOTH_LIGHT) ? 10 : 0;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= (int'($urandom_range(99)) < pct);
         end
      end
   end

   always @(negedge clock) begin : check_colours
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_colours.size() == 0) begin
            flag("colour with no transaction pending", 0, int'(rsp_payload));
         end else begin
            want = pending_colours.pop_front();
            if (rsp_payload.red != want.red) begin
               flag("red", int'(want.red), int'(rsp_payload.red));
            end
            if (rsp_payload.green != want.green) begin
               flag("green", int'(want.green), int'(rsp_payload.green));
            end
            if (rsp_payload.blue != want.blue) begin
               flag("blue", int'(want.blue), int'(rsp_payload.blue));
            end
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      req_payload_type tick_txn;
      req_payload_type zero_txn;
      req_payload_type beat_txn;
      tick_txn.action = ACTION_TICK;
      tick_txn.level  = 16'd0;
      zero_txn.action = ACTION_LEVEL;
      zero_txn.level  = 16'd0;
      beat_txn.action = ACTION_LEVEL;
      beat_txn.level  = 16'd3000;

      // With every component empty the first colour is the dimmest one, and a
      // second identical colour is suppressed.
      plan_mode(1'b0);
      plan_pinned(ACTION_TICK, 0, 1'b1, 1, 1, 1);
      plan_pinned(ACTION_TICK, 0, 1'b0, 0, 0, 0);
      plan_mode(1'b1);
      plan_pinned(ACTION_TICK, 65535, 1'b1, 191, 1, 1);
      plan_pinned(ACTION_TICK, 0, 1'b1, 190, 1, 1);
      // A rise equal to the threshold does not trigger; one more does.
      plan_pinned(ACTION_LEVEL, 204, 1'b0, 0, 0, 0);
      plan_item(ACTION_LEVEL, 0);
      plan_item(ACTION_LEVEL, 205);
      plan_item(ACTION_LEVEL, 1000);
      plan_item(ACTION_LEVEL, 0);
      plan_item(ACTION_LEVEL, 0);
      plan_item(ACTION_LEVEL, 0);
      // Full-scale rise once the hold-off has run out: the value saturates.
      plan_item(ACTION_LEVEL, 65535);
      plan_mode(1'b0);
      plan_pinned(ACTION_TICK, 0, 1'b1, 51, 255, 1);
      plan_item(ACTION_TICK, 65535);
      plan_item(ACTION_LEVEL, 65535);
      plan_item(ACTION_LEVEL, 1);
      plan_item(ACTION_TICK, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == STEP_MODE) begin
            set_mode(script[i].mode);
         end else begin
            offer(script[i].txn, script[i].pinned, script[i].pin_emit, script[i].pin_rgb);
         end
      end

      // Age the components with a run of ticks, let the envelope empty, then
      // trigger three beats and check which component each one reloads.
      repeat (WEAR_TICKS) offer(tick_txn, 1'b0, 1'b0, '0);
      repeat (45) offer(zero_txn, 1'b0, 1'b0, '0);
      for (int b = 0; b < 3; b++) begin
         offer(beat_txn, 1'b0, 1'b0, '0);
         offer(tick_txn, 1'b0, 1'b0, '0);
         repeat (5) offer(zero_txn, 1'b0, 1'b0, '0);
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_mode(ph % 2 == 0);
         set_pace(pace_type'((ph + ph / 2) % 4), ph == 0);
         repeat (PHASE_ITEMS) offer(draw_sample(), 1'b0, 1'b0, '0);
      end

      settle();
      if (mismatches == 0 && pending_colours.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
